@@ hw/rtl/mqlb_pkg.sv @@
// Shared types and constants for the multi-queue linked buffer.
`timescale 1ns / 1ps

package mqlb_pkg;

  // Command codes on the command port.
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DEQ
  } state_t;

  // Payload held in one pool node.
  typedef struct packed {
    logic signed [31:0] key;
    logic [7:0]         chr;
  } item_t;

  localparam logic signed [31:0] EMPTY_KEY  = -32'sd1;
  localparam logic [7:0]         EMPTY_CHAR = 8'd32;

endpackage

@@ hw/rtl/mqlb_node_store.sv @@
// Node pool storage: payload memory and link memory, one shared read address.
`timescale 1ns / 1ps

module mqlb_node_store #(
  parameter int POOL_NODES = 64,
  parameter int NW = 6
) (
  input  logic            clk,
  input  logic            rd_en,
  input  logic [NW-1:0]   rd_addr,
  output mqlb_pkg::item_t rd_item,
  output logic [NW-1:0]   rd_next,
  input  logic            item_we,
  input  logic [NW-1:0]   item_addr,
  input  mqlb_pkg::item_t item_wdata,
  input  logic            next_we,
  input  logic [NW-1:0]   next_addr,
  input  logic [NW-1:0]   next_wdata
);

  mqlb_pkg::item_t item_mem [POOL_NODES];
  logic [NW-1:0]   next_mem [POOL_NODES];

  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_addr] <= item_wdata;
    end
    if (rd_en) begin
      rd_item <= item_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_addr] <= next_wdata;
    end
    if (rd_en) begin
      rd_next <= next_mem[rd_addr];
    end
  end

endmodule

@@ hw/rtl/multi_queue_linked_buffer.sv @@
// Top level: several FIFO queues kept as linked lists over one shared node pool.
// Enqueue, empty dequeue and dropped beats take the accepting edge into S_LOOK, and strobe is
// registered from S_LOOK; a data dequeue passes through S_DEQ before strobe is registered.
// A new command is taken only in S_IDLE (busy is low), after the queue table read and,
// for a data dequeue, the dependent head node read.
// Reset (rst, synchronous): all queues empty, free list empty, fresh count zero.
// The receiver cannot stall; each result is shown for exactly one cycle.
`timescale 1ns / 1ps

module multi_queue_linked_buffer #(
  parameter int NUM_QUEUES = 16,
  parameter int POOL_NODES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               command,
  input  logic [3:0]         queue_index,
  input  logic signed [31:0] data_key,
  input  logic [7:0]         data_char,
  output logic               strobe,
  output logic [1:0]         status,
  output logic signed [31:0] out_key,
  output logic [7:0]         out_char
);

  // Widths: node pointer, node counters (hold POOL_NODES itself), queue address.
  localparam int NW = $clog2(POOL_NODES);
  localparam int CW = $clog2(POOL_NODES + 1);
  localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam logic [CW-1:0] POOL_CNT = CW'(POOL_NODES);
  localparam logic [CW-1:0] ONE_CNT  = CW'(1);

  mqlb_pkg::state_t state, state_next;

  // Accepted command, held for the duration of the beat.
  logic            cmd_r;
  logic [QW-1:0]   q_r;
  logic            q_ok_r;
  mqlb_pkg::item_t item_r;

  // Queue table: {head, tail} per queue, synchronous read.
  logic [2*NW-1:0] qt_mem [NUM_QUEUES];
  logic [2*NW-1:0] qt_rdata;
  logic            qt_we;
  logic [2*NW-1:0] qt_wdata;
  logic [NW-1:0]   q_head, q_tail;

  // Per-queue non-empty flags live in flops so reset clears them at once.
  logic [NUM_QUEUES-1:0] nonempty;
  logic                  ne_set, ne_clr;
  logic                  q_nonempty;

  // Free list and never-used node count.
  logic [NW-1:0] free_head, free_head_next;
  logic [CW-1:0] free_len, free_len_next;
  logic [CW-1:0] fresh_count, fresh_count_next;

  // Node store ports.
  logic            ns_rd_en;
  logic [NW-1:0]   ns_rd_addr;
  mqlb_pkg::item_t ns_rd_item;
  logic [NW-1:0]   ns_rd_next;
  logic            ns_item_we;
  logic [NW-1:0]   ns_item_addr;
  logic            ns_next_we;
  logic [NW-1:0]   ns_next_addr;
  logic [NW-1:0]   ns_next_wdata;

  // Result registers.
  logic                  res_vld_next;
  mqlb_pkg::status_t     res_st, res_st_next;
  logic signed [31:0]    res_key, res_key_next;
  logic [7:0]            res_chr, res_chr_next;

  logic          accept;
  logic          pool_avail;
  logic [NW-1:0] new_node;

  assign busy   = (state != mqlb_pkg::S_IDLE);
  assign accept = start && !busy;

  assign q_head     = qt_rdata[2*NW-1:NW];
  assign q_tail     = qt_rdata[NW-1:0];
  assign q_nonempty = q_ok_r && nonempty[q_r];

  // Free list first, then the next never-used node.
  assign pool_avail = (free_len != '0) || (fresh_count < POOL_CNT);
  assign new_node   = (free_len != '0) ? free_head : fresh_count[NW-1:0];

  // Capture the command and launch the table read and free-list link read.
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= command;
      q_r        <= QW'(queue_index);
      q_ok_r     <= ({28'd0, queue_index} < 32'(NUM_QUEUES));
      item_r.key <= data_key;
      item_r.chr <= data_char;
      qt_rdata   <= qt_mem[QW'(queue_index)];
    end
    if (qt_we) begin
      qt_mem[q_r] <= qt_wdata;
    end
  end

  mqlb_node_store #(
    .POOL_NODES (POOL_NODES),
    .NW         (NW)
  ) u_nodes (
    .clk        (clk),
    .rd_en      (ns_rd_en),
    .rd_addr    (ns_rd_addr),
    .rd_item    (ns_rd_item),
    .rd_next    (ns_rd_next),
    .item_we    (ns_item_we),
    .item_addr  (ns_item_addr),
    .item_wdata (item_r),
    .next_we    (ns_next_we),
    .next_addr  (ns_next_addr),
    .next_wdata (ns_next_wdata)
  );

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      mqlb_pkg::S_IDLE: begin
        if (accept) state_next = mqlb_pkg::S_LOOK;
      end
      mqlb_pkg::S_LOOK: begin
        if (cmd_r == mqlb_pkg::CMD_DEQ && q_nonempty) state_next = mqlb_pkg::S_DEQ;
        else state_next = mqlb_pkg::S_IDLE;
      end
      mqlb_pkg::S_DEQ: state_next = mqlb_pkg::S_IDLE;
      default: state_next = mqlb_pkg::S_IDLE;
    endcase
  end

  // Datapath controls, memory writes and result values.
  always_comb begin
    ns_rd_en         = accept;
    ns_rd_addr       = free_head;     // link of the free-list head, for a pop
    ns_item_we       = 1'b0;
    ns_item_addr     = new_node;
    ns_next_we       = 1'b0;
    ns_next_addr     = q_tail;
    ns_next_wdata    = new_node;
    qt_we            = 1'b0;
    qt_wdata         = qt_rdata;
    ne_set           = 1'b0;
    ne_clr           = 1'b0;
    free_head_next   = free_head;
    free_len_next    = free_len;
    fresh_count_next = fresh_count;
    res_vld_next     = 1'b0;
    res_st_next      = res_st;
    res_key_next     = res_key;
    res_chr_next     = res_chr;
    case (state)
      mqlb_pkg::S_LOOK: begin
        if (cmd_r == mqlb_pkg::CMD_ENQ) begin
          res_vld_next = 1'b1;
          res_key_next = '0;
          res_chr_next = '0;
          if (q_ok_r && pool_avail) begin
            res_st_next = mqlb_pkg::ST_ENQ;
            ns_item_we  = 1'b1;
            // Append behind the old tail, or start a new list.
            ns_next_we  = q_nonempty;
            qt_we       = 1'b1;
            qt_wdata    = {(q_nonempty ? q_head : new_node), new_node};
            ne_set      = 1'b1;
            if (free_len != '0) begin
              free_len_next  = free_len - ONE_CNT;
              free_head_next = (free_len == ONE_CNT) ? '0 : ns_rd_next;
            end else begin
              fresh_count_next = fresh_count + ONE_CNT;
            end
          end else begin
            res_st_next = mqlb_pkg::ST_FULL;
          end
        end else if (q_nonempty) begin
          // Fetch the head node; the result is formed in S_DEQ.
          ns_rd_en   = 1'b1;
          ns_rd_addr = q_head;
        end else begin
          res_vld_next = 1'b1;
          res_st_next  = mqlb_pkg::ST_EMPTY;
          res_key_next = mqlb_pkg::EMPTY_KEY;
          res_chr_next = mqlb_pkg::EMPTY_CHAR;
        end
      end
      mqlb_pkg::S_DEQ: begin
        res_vld_next = 1'b1;
        res_st_next  = mqlb_pkg::ST_DEQ;
        res_key_next = ns_rd_item.key;
        res_chr_next = ns_rd_item.chr;
        if (q_head == q_tail) begin
          ne_clr = 1'b1;
        end else begin
          qt_we    = 1'b1;
          qt_wdata = {ns_rd_next, q_tail};
        end
        // Push the freed node onto the free list.
        ns_next_we     = 1'b1;
        ns_next_addr   = q_head;
        ns_next_wdata  = free_head;
        free_head_next = q_head;
        if (free_len < POOL_CNT) free_len_next = free_len + ONE_CNT;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= mqlb_pkg::S_IDLE;
      nonempty    <= '0;
      free_head   <= '0;
      free_len    <= '0;
      fresh_count <= '0;
      strobe      <= 1'b0;
    end else begin
      state       <= state_next;
      free_head   <= free_head_next;
      free_len    <= free_len_next;
      fresh_count <= fresh_count_next;
      strobe      <= res_vld_next;
      if (ne_set) nonempty[q_r] <= 1'b1;
      if (ne_clr) nonempty[q_r] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    res_st  <= res_st_next;
    res_key <= res_key_next;
    res_chr <= res_chr_next;
  end

  assign status   = res_st;
  assign out_key  = res_key;
  assign out_char = res_chr;

  // A result only ever follows a cycle of work.
  a_strobe_after_work: assert property (@(posedge clk) disable iff (rst)
    strobe |-> $past(state != mqlb_pkg::S_IDLE))
    else $error("result strobe without a command in flight");

  // An accepted command always gets the sequencer going.
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == mqlb_pkg::S_LOOK))
    else $error("accepted beat did not start work");

  // Node bookkeeping never claims more nodes than the pool holds.
  a_pool_bounds: assert property (@(posedge clk) disable iff (rst)
    (free_len <= fresh_count) && (fresh_count <= POOL_CNT))
    else $error("free list or fresh count out of range");

  // A dropped enqueue on a valid queue means the pool is truly exhausted.
  a_full_real: assert property (@(posedge clk) disable iff (rst)
    (state == mqlb_pkg::S_LOOK && cmd_r == mqlb_pkg::CMD_ENQ && q_ok_r && !pool_avail)
    |-> (free_len == '0 && fresh_count == POOL_CNT))
    else $error("pool reported full while nodes remain");

endmodule
